// ===== hw/rtl/iltab_pkg.sv =====
`timescale 1ns / 1ps
package iltab_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_SET    = 2'd1,
    OP_APPEND = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  localparam int unsigned PosW   = 7;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CountW = 8;
  localparam logic [CountW-1:0] CapReset = 8'd100;

  // One accepted item as it travels from the front to the back
  typedef struct packed {
    op_e              op;
    logic [PosW-1:0]  pos;
    logic [ValW-1:0]  val;
  } cmd_t;

  // One finished result
  typedef struct packed {
    status_e            status;
    logic [PosW-1:0]    found_index;
    logic [ValW-1:0]    old_value;
    logic [CountW-1:0]  entry_count;
  } rsp_t;

endpackage

// ===== hw/rtl/iltab_cmd_fifo.sv =====
`timescale 1ns / 1ps
module iltab_cmd_fifo
  import iltab_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t out_cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop;

  assign in_ready_o  = (fill_q != 2'd2);
  assign out_valid_o = (fill_q != 2'd0);
  assign out_cmd_o   = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Store incoming commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_cmd_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3) else $error("command queue fill out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q == 2'd0 |-> !pop) else $error("pop from empty queue");
  a_fill_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> fill_q == $past(fill_q) + 2'd1)
    else $error("fill level lost a push");

endmodule

// ===== hw/rtl/iltab_exec.sv =====
`timescale 1ns / 1ps
module iltab_exec
  import iltab_pkg::*;
#(
  parameter int unsigned Depth = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CountW-1:0] cap_i,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output rsp_t              rsp_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  // Wide enough for the count and for a full position compare
  localparam int unsigned TW = ($clog2(Depth + 1) > CountW) ? $clog2(Depth + 1) : CountW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_SHFT = 5'b00100,
    S_SETR = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  logic [ValW-1:0] mem_q [Depth];
  logic [ValW-1:0] rd_data_q;
  logic            mem_we;
  logic [AW-1:0]   mem_wa, mem_ra;
  logic [ValW-1:0] mem_wd;

  state_e          state_q, state_d;
  cmd_t            cmd_q;
  logic [TW-1:0]   total_q, total_d;
  logic [TW-1:0]   idx_q, idx_d;     // address issued last cycle
  logic            rd_pend_q, rd_pend_d;
  rsp_t            rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;
  logic [TW-1:0]   cap_eff, pos_ext;
  logic            take;

  // Effective capacity is the smaller of the register and the depth
  always_comb begin
    if (TW >= CountW) begin
      cap_eff = (TW'(cap_i) > TW'(Depth)) ? TW'(Depth) : TW'(cap_i);
    end else begin
      cap_eff = (cap_i > CountW'(Depth)) ? TW'(Depth) : TW'(cap_i);
    end
  end
  assign pos_ext = (TW >= PosW) ? TW'(cmd_i.pos) : TW'(cmd_i.pos);

  assign cmd_ready_o = (state_q == S_IDLE) && !rsp_valid_q;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_data_q <= mem_q[mem_ra];
  end

  // Sequencer: scan for lookup, copy-down for remove, read-modify for set, direct write for append
  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    idx_d       = idx_q;
    rd_pend_d   = 1'b0;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q;
    mem_we      = 1'b0;
    mem_wa      = AW'(idx_q);
    mem_wd      = cmd_q.val;
    mem_ra      = AW'(idx_q);
    if (rsp_valid_q && rsp_ready_i) rsp_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          rsp_d.status      = ST_OK;
          rsp_d.found_index = '0;
          rsp_d.old_value   = '0;
          rsp_d.entry_count = CountW'(total_q);
          case (cmd_i.op)
            OP_LOOKUP: begin
              rsp_d.status = ST_NOT_FOUND;
              idx_d        = '0;
              mem_ra       = '0;
              if (total_q != '0) begin
                rd_pend_d = 1'b1;
                state_d   = S_SCAN;
              end else begin
                rsp_valid_d = 1'b1;
              end
            end
            OP_SET: begin
              if (pos_ext >= total_q) begin
                rsp_d.status = ST_BAD_INDEX;
                rsp_valid_d  = 1'b1;
              end else begin
                idx_d   = pos_ext;
                mem_ra  = AW'(pos_ext);
                state_d = S_SETR;
              end
            end
            OP_APPEND: begin
              if (total_q >= cap_eff) begin
                rsp_d.status = ST_FULL;
              end else begin
                mem_we            = 1'b1;
                mem_wa            = AW'(total_q);
                mem_wd            = cmd_i.val;
                total_d           = total_q + 1'b1;
                rsp_d.entry_count = CountW'(total_q + 1'b1);
              end
              rsp_valid_d = 1'b1;
            end
            default: begin
              if (pos_ext >= total_q) begin
                rsp_d.status = ST_BAD_INDEX;
                rsp_valid_d  = 1'b1;
              end else begin
                // read entry pos+1 to move into pos
                idx_d     = pos_ext + 1'b1;
                mem_ra    = AW'(pos_ext + 1'b1);
                rd_pend_d = (pos_ext + 1'b1) < total_q;
                state_d   = S_SHFT;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_data_q == cmd_q.val) begin
          rsp_d.status      = ST_OK;
          rsp_d.found_index = PosW'(idx_q);
          rsp_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end else if (idx_q + 1'b1 >= total_q) begin
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          idx_d     = idx_q + 1'b1;
          mem_ra    = AW'(idx_q + 1'b1);
          rd_pend_d = 1'b1;
        end
      end
      S_SETR: begin
        rsp_d.old_value = rd_data_q;
        mem_we          = 1'b1;
        mem_wa          = AW'(idx_q);
        mem_wd          = cmd_q.val;
        rsp_valid_d     = 1'b1;
        state_d         = S_IDLE;
      end
      S_SHFT: begin
        if (rd_pend_q) begin
          // entry idx_q arrived, store it one place lower
          mem_we = 1'b1;
          mem_wa = AW'(idx_q - 1'b1);
          mem_wd = rd_data_q;
          if (idx_q + 1'b1 < total_q) begin
            idx_d     = idx_q + 1'b1;
            mem_ra    = AW'(idx_q + 1'b1);
            rd_pend_d = 1'b1;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        total_d           = total_q - 1'b1;
        rsp_d.entry_count = CountW'(total_q - 1'b1);
        rsp_valid_d       = 1'b1;
        state_d           = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the command while it is carried out, and register the result
  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_i;
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      idx_q       <= idx_d;
      rd_pend_q   <= rd_pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(Depth)) else $error("entry count above depth");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_ready_i |=> rsp_valid_q && $stable(rsp_q))
    else $error("stalled result changed");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q != $past(total_q) |-> total_q == $past(total_q) + 1'b1
      || total_q == $past(total_q) - 1'b1) else $error("count jumped");
  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !cmd_ready_o) else $error("took item while busy");

endmodule

// ===== hw/rtl/integer_list_table_engine_core.sv =====
`timescale 1ns / 1ps
// Packed list of signed 32-bit integers with lookup, set, append and remove.
// Input channel s_axis: tdata carries operation, position, value; one result
// per item leaves on m_axis with status, found_index, old_value, entry_count.
// cfg_we_i/cfg_wdata_i write the capacity limit (reset 100); write only idle.
// A two-entry command queue lets the front accept items while the back works.
// Work per item, from leaving the queue:
//   append, or any rejected item: answered directly from idle
//   set: memory read, then write
//   lookup: entries scanned up to the match (at most DEPTH)
//   remove at p: entries above p copied down (none for the last entry), then count update
// The next item leaves the queue in the cycle after the result is accepted.
// The pace is set by the single-port-read entry memory, one entry a cycle.
// Reset empties the list; memory contents are not cleared and never read
// before being written. When m_axis stalls, the result is held and the
// back stops; the queue keeps taking up to two more items.
module integer_list_table_engine_core
  import iltab_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // [1:0] operation, [8:2] position, [40:9] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // [1:0] status, [8:2] found_index,
                                     // [40:9] old_value, [48:41] entry_count
);

  logic [CountW-1:0] cap_q;
  cmd_t              in_cmd, q_cmd;
  logic              q_valid, q_ready;
  rsp_t              rsp;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= CapReset;
    else if (cfg_we_i) cap_q <= cfg_wdata_i;
  end

  // Unpack the incoming transaction
  assign in_cmd.op  = op_e'(s_axis_tdata[1:0]);
  assign in_cmd.pos = s_axis_tdata[8:2];
  assign in_cmd.val = s_axis_tdata[40:9];

  iltab_cmd_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (in_cmd),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_cmd_o   (q_cmd)
  );

  iltab_exec #(.Depth(DEPTH)) u_exec (
    .clk_i, .rst_ni,
    .cap_i       (cap_q),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .rsp_valid_o (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .rsp_o       (rsp)
  );

  // Pack the result
  assign m_axis_tdata = {7'd0, rsp.entry_count, rsp.old_value, rsp.found_index,
                         rsp.status};

endmodule
